// ===== rtl/core/piw_pkg.sv =====
// ----------------------------------------------------------------------------
// Price window indicators - shared package
// Widths, reset values and types used across the indicator block.
// ----------------------------------------------------------------------------
package piw_pkg;

   localparam int PRICE_W     = 48;
   localparam int RSI_W       = 23;
   localparam int BAND_W      = 50;
   localparam int PERIOD_W    = 6;

   // running sums of up to 63 prices
   localparam int SUM_W       = 54;
   // shared divider: left-justified dividend, up to 54-bit divisor
   localparam int DIVIDEND_W  = 102;
   localparam int DIVISOR_W   = 54;
   localparam int DIV_CNT_W   = 7;
   // sum of squared deviations and its root
   localparam int ACC_W       = 102;
   localparam int VAR_W       = 96;
   localparam int ROOT_W      = 48;
   localparam int HALF_W      = 24;
   // 2*close + (N-1)*ema
   localparam int EMA_NUM_W   = 55;

   localparam int WINDOW_DEPTH_DEFAULT = 64;

   localparam logic [PERIOD_W-1:0] SHORT_PERIOD_RESET  = 6'd10;
   localparam logic [PERIOD_W-1:0] LONG_PERIOD_RESET   = 6'd50;
   localparam logic [PERIOD_W-1:0] STRENGTH_RESET      = 6'd4;
   localparam logic [PERIOD_W-1:0] BAND_PERIOD_RESET   = 6'd20;
   localparam logic [PERIOD_W-1:0] SMOOTH_PERIOD_RESET = 6'd10;

   // register map, word index
   typedef enum logic [2:0] {
      REG_SHORT    = 3'd0,
      REG_LONG     = 3'd1,
      REG_STRENGTH = 3'd2,
      REG_BAND     = 3'd3,
      REG_SMOOTH   = 3'd4
   } piw_reg_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] short_p;
      logic [PERIOD_W-1:0] long_p;
      logic [PERIOD_W-1:0] strength_p;
      logic [PERIOD_W-1:0] band_p;
      logic [PERIOD_W-1:0] smooth_p;
   } piw_cfg_type;

   typedef struct packed {
      logic                  valid;
      logic [PRICE_W-1:0]    price;
   } piw_queue_type;

endpackage

// ===== rtl/core/piw_intf.sv =====
// ----------------------------------------------------------------------------
// Price window indicators - channel interfaces
// Valid/ready channels for close prices in and indicator words out.
// ----------------------------------------------------------------------------
interface piw_req_if;
   logic                         valid;
   logic                         ready;
   logic [piw_pkg::PRICE_W-1:0]  close_price;

   modport source (output valid, output close_price, input ready);
   modport sink   (input valid, input close_price, output ready);
endinterface

interface piw_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [piw_pkg::PRICE_W-1:0]        short_average;
   logic [piw_pkg::PRICE_W-1:0]        long_average;
   logic [piw_pkg::RSI_W-1:0]          strength_index;
   logic [piw_pkg::PRICE_W-1:0]        band_middle;
   logic [piw_pkg::BAND_W-1:0]         band_upper;
   logic signed [piw_pkg::BAND_W-1:0]  band_lower;
   logic [piw_pkg::PRICE_W-1:0]        smoothed_price;

   modport source (output valid, output short_average, output long_average,
                   output strength_index, output band_middle, output band_upper,
                   output band_lower, output smoothed_price, input ready);
   modport sink   (input valid, input short_average, input long_average,
                   input strength_index, input band_middle, input band_upper,
                   input band_lower, input smoothed_price, output ready);
endinterface

// ===== rtl/core/piw_ram.sv =====
// ----------------------------------------------------------------------------
// Price window indicators - generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module piw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      we,
   input  logic [$clog2(DEPTH)-1:0]  waddr,
   input  logic [WIDTH-1:0]          wdata,
   input  logic [$clog2(DEPTH)-1:0]  raddr,
   output logic [WIDTH-1:0]          rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/piw_front.sv =====
// ----------------------------------------------------------------------------
// Price window indicators - front end
// Takes close prices off the request channel into a two-word queue.
// ----------------------------------------------------------------------------
module piw_front (
   input  logic                         clock,
   input  logic                         reset,
   piw_req_if.sink                      req_chan,
   output piw_pkg::piw_queue_type       head,
   input  logic                         pop
);

   logic [piw_pkg::PRICE_W-1:0] slot_ff [2];
   logic [piw_pkg::PRICE_W-1:0] slot_in [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign req_chan.ready = (count_ff != 2'd2);
   assign push           = req_chan.valid && req_chan.ready;
   assign head.valid     = (count_ff != 2'd0);
   assign head.price     = slot_ff[rd_ptr_ff];

   always_comb begin
      slot_in   = slot_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         slot_in[wr_ptr_ff] = req_chan.close_price;
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      slot_ff <= slot_in;
   end

endmodule

// ===== rtl/core/piw_div.sv =====
// ----------------------------------------------------------------------------
// Price window indicators - serial divider
// Restoring division, one quotient bit per cycle, dividend left-justified.
// ----------------------------------------------------------------------------
module piw_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [piw_pkg::DIVIDEND_W-1:0]     dividend,
   input  logic [piw_pkg::DIVISOR_W-1:0]      divisor,
   input  logic [piw_pkg::DIV_CNT_W-1:0]      count,
   output logic                               done,
   output logic [piw_pkg::DIVIDEND_W-1:0]     quotient
);

   localparam int NW = piw_pkg::DIVIDEND_W;
   localparam int DW = piw_pkg::DIVISOR_W;
   localparam int CW = piw_pkg::DIV_CNT_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] lim_ff, lim_in;
   logic [NW-1:0] num_ff, num_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dsr_ff, dsr_in;
   logic [DW:0]   shifted;
   logic [DW:0]   diff;
   logic          fits;

   assign shifted = {rem_ff, num_ff[NW-1]};
   assign diff    = shifted - {1'b0, dsr_ff};
   assign fits    = (shifted >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      lim_in  = lim_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         lim_in  = count;
         num_in  = dividend;
         quo_in  = '0;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DW-1:0] : shifted[DW-1:0];
         quo_in = {quo_ff[NW-2:0], fits};
         num_in = {num_ff[NW-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == lim_ff - 1'b1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      lim_ff <= lim_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/piw_sqrt.sv =====
// ----------------------------------------------------------------------------
// Price window indicators - serial square root
// Digit-by-digit integer root, one root bit per cycle, truncated.
// ----------------------------------------------------------------------------
module piw_sqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [piw_pkg::VAR_W-1:0]       radicand,
   output logic                            done,
   output logic [piw_pkg::ROOT_W-1:0]      root
);

   localparam int VW = piw_pkg::VAR_W;
   localparam int RW = piw_pkg::ROOT_W;
   localparam int MW = RW + 2;
   localparam int CW = $clog2(RW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [VW-1:0] rad_ff, rad_in;
   logic [RW-1:0] root_ff, root_in;
   logic [MW-1:0] rem_ff, rem_in;
   logic [MW+1:0] shifted;
   logic [MW+1:0] trial;
   logic [MW+1:0] diff;
   logic          fits;

   assign shifted = {rem_ff, rad_ff[VW-1:VW-2]};
   assign trial   = (MW + 2)'({root_ff, 2'b01});
   assign diff    = shifted - trial;
   assign fits    = (shifted >= trial);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         root_in = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[MW-1:0] : shifted[MW-1:0];
         root_in = {root_ff[RW-2:0], fits};
         rad_in  = {rad_ff[VW-3:0], 2'b00};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CW'(RW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== rtl/core/piw_back.sv =====
// ----------------------------------------------------------------------------
// Price window indicators - back end
// Sequencer: writes the ring, walks it for sums, then divides and roots.
// ----------------------------------------------------------------------------
module piw_back #(
   parameter int WINDOW_DEPTH = piw_pkg::WINDOW_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  piw_pkg::piw_cfg_type      cfg,
   input  piw_pkg::piw_queue_type    head,
   output logic                      pop,
   piw_rsp_if.source                 rsp_chan
);

   localparam int PW     = piw_pkg::PRICE_W;
   localparam int PDW    = piw_pkg::PERIOD_W;
   localparam int SW     = piw_pkg::SUM_W;
   localparam int NW     = piw_pkg::DIVIDEND_W;
   localparam int DW     = piw_pkg::DIVISOR_W;
   localparam int CNW    = piw_pkg::DIV_CNT_W;
   localparam int AW     = piw_pkg::ACC_W;
   localparam int HW     = piw_pkg::HALF_W;
   localparam int EW     = piw_pkg::EMA_NUM_W;
   localparam int BW     = piw_pkg::BAND_W;
   localparam int RSW    = piw_pkg::RSI_W;
   localparam int ADDR_W = $clog2(WINDOW_DEPTH);
   localparam int SEEN_W = $clog2(WINDOW_DEPTH + 1);
   localparam int CMP_W  = (SEEN_W > 7) ? SEEN_W : 7;
   localparam int GAIN25_W = SW + 5;
   // a strength window of 63 changes looks back 64 closes
   localparam logic [6:0] WALK_LEN = 7'd64;
   localparam logic [RSW-1:0] RSI_FULL = 23'd6553600;

   typedef enum logic [3:0] {
      S_IDLE, S_WALK, S_DIV_GO, S_DIV_WAIT, S_DEV_ADDR, S_DEV_DIFF,
      S_MUL0, S_MUL1, S_MUL2, S_DEV_FLUSH, S_VAR_GO, S_VAR_WAIT,
      S_SQRT_GO, S_SQRT_WAIT, S_FINISH
   } state_type;

   typedef enum logic [2:0] {
      OP_BAND, OP_SHORT, OP_LONG, OP_EMA, OP_RSI
   } op_type;

   function automatic logic [ADDR_W-1:0] step_back(input logic [ADDR_W-1:0] p);
      logic [ADDR_W-1:0] r;
      r = (p == '0) ? ADDR_W'(WINDOW_DEPTH - 1) : p - 1'b1;
      return r;
   endfunction

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [ADDR_W-1:0]  slot_ff, slot_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [ADDR_W-1:0]  ptr_ff, ptr_in;
   logic [SEEN_W-1:0]  seen_ff, seen_in;
   logic               first_ff, first_in;
   logic [PW-1:0]      ema_ff, ema_in;
   logic [EW-1:0]      ema_num_ff, ema_num_in;
   logic [6:0]         issue_ff, issue_in;
   logic [6:0]         dk_ff, dk_in;
   logic               dvalid_ff, dvalid_in;
   logic [PW-1:0]      prev_ff, prev_in;
   logic [SW-1:0]      sum_s_ff, sum_s_in;
   logic [SW-1:0]      sum_l_ff, sum_l_in;
   logic [SW-1:0]      sum_b_ff, sum_b_in;
   logic [SW-1:0]      gain_ff, gain_in;
   logic [SW-1:0]      loss_ff, loss_in;
   logic [PW-1:0]      q_mid_ff, q_mid_in;
   logic [PW-1:0]      q_short_ff, q_short_in;
   logic [PW-1:0]      q_long_ff, q_long_in;
   logic [RSW-1:0]     q_rsi_ff, q_rsi_in;
   logic [6:0]         dcnt_ff, dcnt_in;
   logic [PW-1:0]      d_ff, d_in;
   logic [2*PW-1:0]    prod_ff, prod_in;
   logic               pv_ff, pv_in;
   logic [AW-1:0]      acc_ff, acc_in;
   logic [PW-1:0]      sd_ff, sd_in;

   logic               out_valid_ff, out_valid_in;
   logic [PW-1:0]      out_short_ff, out_short_in;
   logic [PW-1:0]      out_long_ff, out_long_in;
   logic [RSW-1:0]     out_rsi_ff, out_rsi_in;
   logic [PW-1:0]      out_mid_ff, out_mid_in;
   logic [BW-1:0]      out_upper_ff, out_upper_in;
   logic [BW-1:0]      out_lower_ff, out_lower_in;
   logic [PW-1:0]      out_ema_ff, out_ema_in;

   logic               ram_we;
   logic [PW-1:0]      ram_rdata;

   logic               div_start;
   logic [NW-1:0]      div_dividend;
   logic [DW-1:0]      div_divisor;
   logic [CNW-1:0]     div_count;
   logic               div_done;
   logic [NW-1:0]      div_quo;

   logic               sqrt_done;
   logic [PW-1:0]      sqrt_root;

   logic [HW-1:0]      mul_a, mul_b;
   logic [2*HW-1:0]    mul_p;
   logic [2*PW-1:0]    mul_shifted;

   logic [PW-1:0]      smooth_n;
   logic [PDW-1:0]     smooth_m1;
   logic [PDW+PW-1:0]  ema_scaled;
   logic [GAIN25_W-1:0] gain25;
   logic [CMP_W-1:0]   seen_x;
   logic               short_ok, long_ok, rsi_ok, mid_ok, dev_ok, ema_ok;
   logic [PW-1:0]      mid_val;
   logic [BW-1:0]      mid_x, sd2_x;

   piw_ram #(.WIDTH(PW), .DEPTH(WINDOW_DEPTH)) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (slot_ff),
      .wdata (head.price),
      .raddr (ptr_ff),
      .rdata (ram_rdata)
   );

   piw_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .count    (div_count),
      .done     (div_done),
      .quotient (div_quo)
   );

   piw_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_SQRT_GO),
      .radicand (div_quo[piw_pkg::VAR_W-1:0]),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // window fill checks against the updated close count
   assign seen_x   = CMP_W'(seen_ff);
   assign smooth_n = (cfg.smooth_p == '0) ? PW'(1) : PW'(cfg.smooth_p);
   assign smooth_m1 = PDW'(smooth_n - 1'b1);
   // (N-1)*ema: a 6 x 48 product
   assign ema_scaled = smooth_m1 * ema_ff;
   assign short_ok = (cfg.short_p != '0) && (seen_x >= CMP_W'(cfg.short_p));
   assign long_ok  = (cfg.long_p != '0) && (seen_x >= CMP_W'(cfg.long_p));
   assign rsi_ok   = (cfg.strength_p != '0) &&
                     (seen_x >= CMP_W'(cfg.strength_p) + 1'b1);
   assign mid_ok   = (cfg.band_p != '0) && (seen_x >= CMP_W'(cfg.band_p));
   assign dev_ok   = (cfg.band_p != '0) &&
                     (seen_x >= CMP_W'(cfg.band_p) + 1'b1);
   assign ema_ok   = (seen_x >= CMP_W'(smooth_n));

   assign gain25 = (GAIN25_W'(gain_ff) << 4) + (GAIN25_W'(gain_ff) << 3)
                 + GAIN25_W'(gain_ff);

   // divider operands: sums, EMA numerator, scaled gain, then variance
   always_comb begin
      div_start    = (state_ff == S_DIV_GO) || (state_ff == S_VAR_GO);
      div_dividend = {sum_b_ff, (NW - SW)'(0)};
      div_divisor  = DW'(cfg.band_p);
      div_count    = CNW'(SW);
      if (state_ff == S_VAR_GO) begin
         div_dividend = acc_ff;
         div_divisor  = DW'(cfg.band_p);
         div_count    = CNW'(AW);
      end else begin
         case (op_ff)
            OP_BAND: begin
               div_dividend = {sum_b_ff, (NW - SW)'(0)};
               div_divisor  = DW'(cfg.band_p);
               div_count    = CNW'(SW);
            end
            OP_SHORT: begin
               div_dividend = {sum_s_ff, (NW - SW)'(0)};
               div_divisor  = DW'(cfg.short_p);
               div_count    = CNW'(SW);
            end
            OP_LONG: begin
               div_dividend = {sum_l_ff, (NW - SW)'(0)};
               div_divisor  = DW'(cfg.long_p);
               div_count    = CNW'(SW);
            end
            OP_EMA: begin
               div_dividend = {ema_num_ff, (NW - EW)'(0)};
               div_divisor  = DW'(smooth_n) + 1'b1;
               div_count    = CNW'(EW);
            end
            OP_RSI: begin
               // gain*100*2^16 = gain*25 followed by 18 zero bits
               div_dividend = {gain25, (NW - GAIN25_W)'(0)};
               div_divisor  = gain_ff + loss_ff;
               div_count    = CNW'(GAIN25_W + 18);
            end
            default: begin
               div_dividend = '0;
               div_divisor  = '0;
               div_count    = CNW'(1);
            end
         endcase
      end
   end

   // one 24x24 partial product per cycle for d*d
   always_comb begin
      mul_a = (state_ff == S_MUL2) ? d_ff[PW-1:HW] : d_ff[HW-1:0];
      mul_b = (state_ff == S_MUL0) ? d_ff[HW-1:0] : d_ff[PW-1:HW];
      mul_p = mul_a * mul_b;
      case (state_ff)
         S_MUL1:  mul_shifted = (2*PW)'(mul_p) << (HW + 1);
         S_MUL2:  mul_shifted = (2*PW)'(mul_p) << (2*HW);
         default: mul_shifted = (2*PW)'(mul_p);
      endcase
   end

   assign mid_val = mid_ok ? q_mid_ff : '0;
   assign mid_x   = BW'(mid_val);
   assign sd2_x   = BW'({sd_ff, 1'b0});

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      slot_in    = slot_ff;
      base_in    = base_ff;
      ptr_in     = ptr_ff;
      seen_in    = seen_ff;
      first_in   = first_ff;
      ema_in     = ema_ff;
      ema_num_in = ema_num_ff;
      issue_in   = issue_ff;
      dk_in      = dk_ff;
      dvalid_in  = dvalid_ff;
      prev_in    = prev_ff;
      sum_s_in   = sum_s_ff;
      sum_l_in   = sum_l_ff;
      sum_b_in   = sum_b_ff;
      gain_in    = gain_ff;
      loss_in    = loss_ff;
      q_mid_in   = q_mid_ff;
      q_short_in = q_short_ff;
      q_long_in  = q_long_ff;
      q_rsi_in   = q_rsi_ff;
      dcnt_in    = dcnt_ff;
      d_in       = d_ff;
      prod_in    = prod_ff;
      pv_in      = 1'b0;
      acc_in     = acc_ff;
      sd_in      = sd_ff;
      out_valid_in = out_valid_ff;
      out_short_in = out_short_ff;
      out_long_in  = out_long_ff;
      out_rsi_in   = out_rsi_ff;
      out_mid_in   = out_mid_ff;
      out_upper_in = out_upper_ff;
      out_lower_in = out_lower_ff;
      out_ema_in   = out_ema_ff;
      ram_we = 1'b0;
      pop    = 1'b0;

      if (pv_ff) begin
         acc_in = acc_ff + AW'(prod_ff);
      end
      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               pop     = 1'b1;
               ram_we  = 1'b1;
               base_in = slot_ff;
               ptr_in  = slot_ff;
               slot_in = (slot_ff == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
               if (seen_ff < SEEN_W'(WINDOW_DEPTH)) begin
                  seen_in = seen_ff + 1'b1;
               end
               first_in = (seen_ff == '0);
               if (seen_ff == '0) begin
                  ema_in = head.price;
               end
               ema_num_in = EW'({head.price, 1'b0}) + EW'(ema_scaled);
               sum_s_in  = '0;
               sum_l_in  = '0;
               sum_b_in  = '0;
               gain_in   = '0;
               loss_in   = '0;
               issue_in  = '0;
               dvalid_in = 1'b0;
               state_in  = S_WALK;
            end
         end

         // pipelined walk, newest close first; read data is registered in the RAM and lags the address
         S_WALK: begin
            if (issue_ff != WALK_LEN) begin
               ptr_in    = step_back(ptr_ff);
               issue_in  = issue_ff + 1'b1;
               dk_in     = issue_ff + 1'b1;
               dvalid_in = 1'b1;
            end else begin
               dvalid_in = 1'b0;
            end
            if (dvalid_ff) begin
               prev_in = ram_rdata;
               if (dk_ff <= {1'b0, cfg.short_p}) begin
                  sum_s_in = sum_s_ff + SW'(ram_rdata);
               end
               if (dk_ff <= {1'b0, cfg.long_p}) begin
                  sum_l_in = sum_l_ff + SW'(ram_rdata);
               end
               if (dk_ff <= {1'b0, cfg.band_p}) begin
                  sum_b_in = sum_b_ff + SW'(ram_rdata);
               end
               // change from this close to the newer one read just before
               if ((dk_ff >= 7'd2) && (dk_ff <= {1'b0, cfg.strength_p} + 7'd1)) begin
                  if (prev_ff > ram_rdata) begin
                     gain_in = gain_ff + SW'(prev_ff - ram_rdata);
                  end else begin
                     loss_in = loss_ff + SW'(ram_rdata - prev_ff);
                  end
               end
               if (dk_ff == WALK_LEN) begin
                  dvalid_in = 1'b0;
                  op_in     = OP_BAND;
                  state_in  = S_DIV_GO;
               end
            end
         end

         S_DIV_GO: begin
            state_in = S_DIV_WAIT;
         end

         S_DIV_WAIT: begin
            if (div_done) begin
               state_in = S_DIV_GO;
               case (op_ff)
                  OP_BAND: begin
                     q_mid_in = div_quo[PW-1:0];
                     op_in    = OP_SHORT;
                  end
                  OP_SHORT: begin
                     q_short_in = div_quo[PW-1:0];
                     op_in      = OP_LONG;
                  end
                  OP_LONG: begin
                     q_long_in = div_quo[PW-1:0];
                     op_in     = first_ff ? OP_RSI : OP_EMA;
                  end
                  OP_EMA: begin
                     ema_in = div_quo[PW-1:0];
                     op_in  = OP_RSI;
                  end
                  OP_RSI: begin
                     q_rsi_in = div_quo[RSW-1:0];
                     if (dev_ok) begin
                        ptr_in   = base_ff;
                        dcnt_in  = '0;
                        acc_in   = '0;
                        state_in = S_DEV_ADDR;
                     end else begin
                        sd_in    = '0;
                        state_in = S_FINISH;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_DEV_ADDR: begin
            ptr_in   = step_back(ptr_ff);
            state_in = S_DEV_DIFF;
         end

         S_DEV_DIFF: begin
            d_in     = (ram_rdata >= q_mid_ff) ? ram_rdata - q_mid_ff : q_mid_ff - ram_rdata;
            dcnt_in  = dcnt_ff + 1'b1;
            state_in = S_MUL0;
         end

         S_MUL0: begin
            prod_in  = mul_shifted;
            pv_in    = 1'b1;
            state_in = S_MUL1;
         end

         S_MUL1: begin
            prod_in  = mul_shifted;
            pv_in    = 1'b1;
            state_in = S_MUL2;
         end

         S_MUL2: begin
            prod_in  = mul_shifted;
            pv_in    = 1'b1;
            state_in = (dcnt_ff == {1'b0, cfg.band_p}) ? S_DEV_FLUSH : S_DEV_ADDR;
         end

         S_DEV_FLUSH: begin
            state_in = S_VAR_GO;
         end

         S_VAR_GO: begin
            state_in = S_VAR_WAIT;
         end

         S_VAR_WAIT: begin
            if (div_done) begin
               state_in = S_SQRT_GO;
            end
         end

         S_SQRT_GO: begin
            state_in = S_SQRT_WAIT;
         end

         S_SQRT_WAIT: begin
            if (sqrt_done) begin
               sd_in    = sqrt_root;
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_valid_in = 1'b1;
               out_short_in = short_ok ? q_short_ff : '0;
               out_long_in  = long_ok ? q_long_ff : '0;
               out_rsi_in   = !rsi_ok ? '0 : ((loss_ff == '0) ? RSI_FULL : q_rsi_ff);
               out_mid_in   = mid_val;
               out_upper_in = mid_x + sd2_x;
               out_lower_in = mid_x - sd2_x;
               out_ema_in   = ema_ok ? ema_ff : '0;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_BAND;
         slot_ff      <= '0;
         seen_ff      <= '0;
         ema_ff       <= '0;
         dvalid_ff    <= 1'b0;
         pv_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         slot_ff      <= slot_in;
         seen_ff      <= seen_in;
         ema_ff       <= ema_in;
         dvalid_ff    <= dvalid_in;
         pv_ff        <= pv_in;
         out_valid_ff <= out_valid_in;
      end
      base_ff      <= base_in;
      ptr_ff       <= ptr_in;
      first_ff     <= first_in;
      ema_num_ff   <= ema_num_in;
      issue_ff     <= issue_in;
      dk_ff        <= dk_in;
      prev_ff      <= prev_in;
      sum_s_ff     <= sum_s_in;
      sum_l_ff     <= sum_l_in;
      sum_b_ff     <= sum_b_in;
      gain_ff      <= gain_in;
      loss_ff      <= loss_in;
      q_mid_ff     <= q_mid_in;
      q_short_ff   <= q_short_in;
      q_long_ff    <= q_long_in;
      q_rsi_ff     <= q_rsi_in;
      dcnt_ff      <= dcnt_in;
      d_ff         <= d_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      sd_ff        <= sd_in;
      out_short_ff <= out_short_in;
      out_long_ff  <= out_long_in;
      out_rsi_ff   <= out_rsi_in;
      out_mid_ff   <= out_mid_in;
      out_upper_ff <= out_upper_in;
      out_lower_ff <= out_lower_in;
      out_ema_ff   <= out_ema_in;
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.short_average  = out_short_ff;
   assign rsp_chan.long_average   = out_long_ff;
   assign rsp_chan.strength_index = out_rsi_ff;
   assign rsp_chan.band_middle    = out_mid_ff;
   assign rsp_chan.band_upper     = out_upper_ff;
   assign rsp_chan.band_lower     = signed'(out_lower_ff);
   assign rsp_chan.smoothed_price = out_ema_ff;

endmodule

// ===== rtl/core/price_window_indicators.sv =====
// ----------------------------------------------------------------------------
// Price window indicators - top level
// One close price per word in, one word of indicators out: short and long
// moving averages, RSI, Bollinger middle/upper/lower bands and an EMA. Most
// of the work per item is the single shared one-bit-per-cycle divider (four
// to six divisions of 54 to 102 bits) and the 64-read walk of the price
// ring through its one read port; once the band window is filled, a ring
// read, a difference and three 24x24 partial products of the squared
// deviation per band close and a square root are added. A two-word input
// queue keeps taking prices while one is processed, and a finished result
// waits in an output register while the next item is processed; that
// item's result is held until the first is taken. No clearing pass after
// reset; the ring needs none.
// ----------------------------------------------------------------------------
module price_window_indicators #(
   parameter int WINDOW_DEPTH = piw_pkg::WINDOW_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   piw_req_if.sink      req_chan,
   piw_rsp_if.source    rsp_chan,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [4:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   localparam int PDW = piw_pkg::PERIOD_W;

   piw_pkg::piw_cfg_type   cfg_ff, cfg_in;
   piw_pkg::piw_queue_type head;
   logic                   pop;
   logic                   wr_en;
   logic [2:0]             reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   // register map, word addressed
   assign reg_idx = paddr[4:2];

   // writes to unmapped words fall through untouched
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            piw_pkg::REG_SHORT:    cfg_in.short_p    = pwdata[PDW-1:0];
            piw_pkg::REG_LONG:     cfg_in.long_p     = pwdata[PDW-1:0];
            piw_pkg::REG_STRENGTH: cfg_in.strength_p = pwdata[PDW-1:0];
            piw_pkg::REG_BAND:     cfg_in.band_p     = pwdata[PDW-1:0];
            piw_pkg::REG_SMOOTH:   cfg_in.smooth_p   = pwdata[PDW-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         piw_pkg::REG_SHORT:    prdata = 32'(cfg_ff.short_p);
         piw_pkg::REG_LONG:     prdata = 32'(cfg_ff.long_p);
         piw_pkg::REG_STRENGTH: prdata = 32'(cfg_ff.strength_p);
         piw_pkg::REG_BAND:     prdata = 32'(cfg_ff.band_p);
         piw_pkg::REG_SMOOTH:   prdata = 32'(cfg_ff.smooth_p);
         default:               prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_p    <= piw_pkg::SHORT_PERIOD_RESET;
         cfg_ff.long_p     <= piw_pkg::LONG_PERIOD_RESET;
         cfg_ff.strength_p <= piw_pkg::STRENGTH_RESET;
         cfg_ff.band_p     <= piw_pkg::BAND_PERIOD_RESET;
         cfg_ff.smooth_p   <= piw_pkg::SMOOTH_PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: input queue
   piw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .head     (head),
      .pop      (pop)
   );

   // back: ring, sums, divisions, root, result register
   piw_back #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule
